// File: rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the sparse tiled texel store
// Item layouts, command codes, register indexes and store geometry.
// ----------------------------------------------------------------------------
package stt_pkg;

  // store geometry
  localparam int TILE_SLOTS  = 64;
  localparam int SLOT_W      = 6;
  localparam int MAX_LOG2    = 4;
  localparam int LOC_W       = 2 * MAX_LOG2;
  localparam int ADDR_W      = SLOT_W + LOC_W;
  localparam int MEM_DEPTH   = TILE_SLOTS << LOC_W;
  localparam int CNT_W       = 7;

  // configuration register indexes
  localparam logic REG_TILE_LOG2 = 1'b0;
  localparam logic REG_RES       = 1'b1;

  // commands
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SAMPLE = 2'd3
  } cmd_e;

  // input item
  typedef struct packed {
    logic        [1:0]  cmd;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic        [16:0] u_pos;
    logic        [16:0] v_pos;
    logic signed [31:0] val_x;
    logic signed [31:0] val_y;
    logic signed [31:0] val_z;
  } item_t;

  // result item
  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic               status;
  } result_t;

  // classified item passed from front to back
  typedef struct packed {
    cmd_e                         cmd;
    logic                         alloc;
    logic                         status;
    logic [3:0][ADDR_W-1:0]       addr;
    logic [3:0]                   pres;
    logic [15:0]                  ax;
    logic [15:0]                  ay;
    logic [2:0][31:0]             val;
  } qent_t;

endpackage

// File: rtl/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue: two-entry queue between front and back
// Decouples tile lookup from texel memory work.
// ----------------------------------------------------------------------------
module stt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  stt_pkg::qent_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output stt_pkg::qent_t pop_data_o
);

  stt_pkg::qent_t ent_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = cnt_q == 2'd2;
  assign valid_o    = cnt_q != 2'd0;
  assign pop_data_o = ent_q[rd_q];

  // pointers and fill count
  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue underflow");

endmodule

// File: rtl/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front: item intake, sample tap setup and tile table lookup
// Resolves each tap to a slot address and allocates tiles for writes and adds.
// ----------------------------------------------------------------------------
module stt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  stt_pkg::item_t item_i,
  output logic           busy_o,
  input  logic [2:0]     k_i,
  input  logic [16:0]    res_i,
  input  logic           q_full_i,
  output logic           push_o,
  output stt_pkg::qent_t push_data_o
);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_COORD = 4'b0010,
    F_LOOK  = 4'b0100,
    F_PUSH  = 4'b1000
  } fst_e;

  fst_e                st_q;
  stt_pkg::item_t      it_q;
  stt_pkg::qent_t      ent_q;
  logic signed [18:0]  ox_q, oy_q;
  logic [1:0]          tap_q;
  logic [stt_pkg::TILE_SLOTS-1:0] valid_q;
  logic signed [15:0]  tx_q [stt_pkg::TILE_SLOTS];
  logic signed [15:0]  ty_q [stt_pkg::TILE_SLOTS];
  logic [stt_pkg::CNT_W-1:0] used_q;

  logic signed [18:0]  px, py;
  logic                inr;
  logic signed [15:0]  cx, cy, tilex, tiley;
  logic [7:0]          mask8, lidx;
  logic                hit, full;
  logic [stt_pkg::SLOT_W-1:0] hit_idx, free_idx, slot;
  logic [33:0]         bx, by;
  logic                is_wr;

  assign busy_o      = st_q != F_IDLE;
  assign push_o      = (st_q == F_PUSH) && !q_full_i;
  assign push_data_o = ent_q;

  // sample point offset by half a texel
  assign bx = {17'd0, it_q.u_pos} * {17'd0, res_i} + 34'd32768;
  assign by = {17'd0, it_q.v_pos} * {17'd0, res_i} + 34'd32768;

  // tap coordinate split into tile and local parts
  always_comb begin
    px    = ox_q + 19'(tap_q[0]);
    py    = oy_q + 19'(tap_q[1]);
    inr   = ((px[18:15] == 4'b0000) || (px[18:15] == 4'b1111)) &&
            ((py[18:15] == 4'b0000) || (py[18:15] == 4'b1111));
    cx    = px[15:0];
    cy    = py[15:0];
    tilex = cx >>> k_i;
    tiley = cy >>> k_i;
    mask8 = 8'((9'd1 << k_i) - 9'd1);
    lidx  = ((cy[7:0] & mask8) << k_i) | (cx[7:0] & mask8);
  end

  // tile table search and first free slot
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = stt_pkg::TILE_SLOTS - 1; i >= 0; i--) begin
      if (valid_q[i] && tx_q[i] == tilex && ty_q[i] == tiley) begin
        hit     = inr;
        hit_idx = stt_pkg::SLOT_W'(i);
      end
      if (!valid_q[i]) begin
        free_idx = stt_pkg::SLOT_W'(i);
      end
    end
    full  = used_q == stt_pkg::CNT_W'(stt_pkg::TILE_SLOTS);
    is_wr = (ent_q.cmd == stt_pkg::CMD_WRITE) || (ent_q.cmd == stt_pkg::CMD_ADD);
    slot  = hit ? hit_idx : free_idx;
  end

  // control and tile table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= F_IDLE;
      tap_q   <= 2'd0;
      valid_q <= '0;
      used_q  <= '0;
    end else begin
      case (st_q)
        F_IDLE: begin
          if (start_i) begin
            tap_q <= 2'd0;
            st_q  <= (stt_pkg::cmd_e'(item_i.cmd) == stt_pkg::CMD_SAMPLE) ? F_COORD
                                                                          : F_LOOK;
          end
        end
        F_COORD: st_q <= F_LOOK;
        F_LOOK: begin
          if (is_wr && !hit && !full) begin
            valid_q[free_idx] <= 1'b1;
            used_q            <= used_q + 1'b1;
          end
          if (ent_q.cmd == stt_pkg::CMD_SAMPLE && tap_q != 2'd3) begin
            tap_q <= tap_q + 2'd1;
          end else begin
            st_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full_i) begin
            st_q <= F_IDLE;
          end
        end
        default: st_q <= F_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (st_q == F_IDLE && start_i) begin
      it_q          <= item_i;
      ent_q.cmd     <= stt_pkg::cmd_e'(item_i.cmd);
      ent_q.alloc   <= 1'b0;
      ent_q.status  <= 1'b0;
      ent_q.pres    <= '0;
      ent_q.ax      <= '0;
      ent_q.ay      <= '0;
      ent_q.val[0]  <= item_i.val_x;
      ent_q.val[1]  <= item_i.val_y;
      ent_q.val[2]  <= item_i.val_z;
      ox_q          <= 19'(item_i.coord_x);
      oy_q          <= 19'(item_i.coord_y);
    end
    if (st_q == F_COORD) begin
      ox_q     <= $signed({1'b0, bx[33:16]}) - 19'sd1;
      oy_q     <= $signed({1'b0, by[33:16]}) - 19'sd1;
      ent_q.ax <= bx[15:0];
      ent_q.ay <= by[15:0];
    end
    if (st_q == F_LOOK) begin
      ent_q.addr[tap_q] <= {slot, lidx};
      ent_q.pres[tap_q] <= hit;
      if (is_wr && !hit) begin
        if (full) begin
          ent_q.status <= 1'b1;
        end else begin
          ent_q.alloc    <= 1'b1;
          tx_q[free_idx] <= tilex;
          ty_q[free_idx] <= tiley;
        end
      end
    end
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= stt_pkg::CNT_W'(stt_pkg::TILE_SLOTS)) else $error("slot count overrun");
  a_used_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(used_q)) else $error("slot count mismatch");

endmodule

// File: rtl/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back: texel memory, tile clearing and bilinear filter
// Executes classified items in order and drives the result strobe.
// ----------------------------------------------------------------------------
module stt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  stt_pkg::qent_t   q_data_i,
  output logic             pop_o,
  output logic             res_valid_o,
  output stt_pkg::result_t result_o
);

  typedef enum logic [8:0] {
    B_IDLE   = 9'b000000001,
    B_CLEAR  = 9'b000000010,
    B_EXEC   = 9'b000000100,
    B_ADDW   = 9'b000001000,
    B_RDW    = 9'b000010000,
    B_TAPRD  = 9'b000100000,
    B_TAPACC = 9'b001000000,
    B_MUL0   = 9'b010000000,
    B_MUL1   = 9'b100000000
  } bst_e;

  bst_e               st_q, st_d;
  stt_pkg::qent_t     cur_q;
  logic [7:0]         cnt_q;
  logic [1:0]         tap_q;
  logic signed [50:0] row0_q [3];
  logic signed [50:0] row1_q [3];
  logic signed [69:0] m_q    [3];
  logic               rv_q, rv_d;
  stt_pkg::result_t   res_q, res_d;

  logic [95:0] mem [stt_pkg::MEM_DEPTH];
  logic [95:0] rdata_q;
  logic        we, re;
  logic [stt_pkg::ADDR_W-1:0] waddr, raddr;
  logic [95:0] wdata;

  logic [16:0]        wx0, wx1, wy0, wy1, wt;
  logic signed [31:0] d    [3];
  logic signed [50:0] pm   [3];
  logic signed [69:0] s    [3];
  logic signed [69:0] rnd  [3];
  logic signed [32:0] sum  [3];
  logic [31:0]        sat  [3];

  assign res_valid_o = rv_q;
  assign result_o    = res_q;
  assign pop_o       = (st_q == B_IDLE) && q_valid_i;

  // filter weights
  assign wx1 = {1'b0, cur_q.ax};
  assign wy1 = {1'b0, cur_q.ay};
  assign wx0 = 17'h10000 - wx1;
  assign wy0 = 17'h10000 - wy1;
  assign wt  = tap_q[0] ? wx1 : wx0;

  // per component arithmetic
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d[c]   = cur_q.pres[tap_q] ? rdata_q[c*32 +: 32] : 32'sd0;
      pm[c]  = 51'(d[c]) * 51'($signed({1'b0, wt}));
      s[c]   = m_q[c] + 70'(row1_q[c]) * 70'($signed({1'b0, wy1}));
      rnd[c] = s[c] + 70'sd2147483648;
      sum[c] = 33'($signed(rdata_q[c*32 +: 32])) + 33'($signed(cur_q.val[c]));
      if (sum[c][32] != sum[c][31]) begin
        sat[c] = sum[c][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        sat[c] = sum[c][31:0];
      end
    end
  end

  // sequencer
  always_comb begin
    st_d  = st_q;
    rv_d  = 1'b0;
    res_d = '0;
    we    = 1'b0;
    waddr = cur_q.addr[0];
    wdata = '0;
    re    = 1'b0;
    raddr = cur_q.addr[tap_q];
    case (st_q)
      B_IDLE: begin
        if (q_valid_i) begin
          st_d = q_data_i.alloc ? B_CLEAR : B_EXEC;
        end
      end
      B_CLEAR: begin
        we    = 1'b1;
        waddr = {cur_q.addr[0][stt_pkg::ADDR_W-1 -: stt_pkg::SLOT_W], cnt_q};
        if (cnt_q == 8'hFF) begin
          st_d = B_EXEC;
        end
      end
      B_EXEC: begin
        case (cur_q.cmd)
          stt_pkg::CMD_WRITE: begin
            we           = !cur_q.status;
            wdata        = {cur_q.val[2], cur_q.val[1], cur_q.val[0]};
            rv_d         = 1'b1;
            res_d.status = cur_q.status;
            st_d         = B_IDLE;
          end
          stt_pkg::CMD_ADD: begin
            if (cur_q.status) begin
              rv_d         = 1'b1;
              res_d.status = 1'b1;
              st_d         = B_IDLE;
            end else begin
              re   = 1'b1;
              st_d = B_ADDW;
            end
          end
          stt_pkg::CMD_READ: begin
            if (cur_q.pres[0]) begin
              re   = 1'b1;
              st_d = B_RDW;
            end else begin
              rv_d = 1'b1;
              st_d = B_IDLE;
            end
          end
          stt_pkg::CMD_SAMPLE: st_d = B_TAPRD;
          default: st_d = B_IDLE;
        endcase
      end
      B_ADDW: begin
        we    = 1'b1;
        wdata = {sat[2], sat[1], sat[0]};
        rv_d  = 1'b1;
        st_d  = B_IDLE;
      end
      B_RDW: begin
        rv_d        = 1'b1;
        res_d.res_x = rdata_q[31:0];
        res_d.res_y = rdata_q[63:32];
        res_d.res_z = rdata_q[95:64];
        st_d        = B_IDLE;
      end
      B_TAPRD: begin
        re   = 1'b1;
        st_d = B_TAPACC;
      end
      B_TAPACC: st_d = (tap_q == 2'd3) ? B_MUL0 : B_TAPRD;
      B_MUL0:   st_d = B_MUL1;
      B_MUL1: begin
        rv_d        = 1'b1;
        res_d.res_x = rnd[0][63:32];
        res_d.res_y = rnd[1][63:32];
        res_d.res_z = rnd[2][63:32];
        st_d        = B_IDLE;
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= B_IDLE;
      rv_q  <= 1'b0;
      cnt_q <= 8'd0;
      tap_q <= 2'd0;
    end else begin
      st_q <= st_d;
      rv_q <= rv_d;
      if (st_q == B_CLEAR) begin
        cnt_q <= cnt_q + 8'd1;
      end
      if (st_q == B_IDLE) begin
        tap_q <= 2'd0;
      end else if (st_q == B_TAPACC) begin
        tap_q <= tap_q + 2'd1;
      end
    end
  end

  // payload and filter accumulators
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (pop_o) begin
      cur_q <= q_data_i;
    end
    if (st_q == B_TAPACC) begin
      for (int c = 0; c < 3; c++) begin
        if (!tap_q[1]) begin
          row0_q[c] <= tap_q[0] ? row0_q[c] + pm[c] : pm[c];
        end else begin
          row1_q[c] <= tap_q[0] ? row1_q[c] + pm[c] : pm[c];
        end
      end
    end
    if (st_q == B_MUL0) begin
      for (int c = 0; c < 3; c++) begin
        m_q[c] <= 70'(row0_q[c]) * 70'($signed({1'b0, wy0}));
      end
    end
  end

  // texel memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  a_emit_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> $past(st_q) != B_IDLE) else $error("result without work");
  a_clear_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_CLEAR && $past(st_q) == B_IDLE) |-> cnt_q == 8'd0)
    else $error("clear sweep misaligned");

endmodule

// File: rtl/sparse_tiled_texel_store_bilinear.sv
// ----------------------------------------------------------------------------
// sparse_tiled_texel_store_bilinear: sparse tiled texel store with sampler
// Top level: configuration registers, front, queue and back.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low; each item gives
// exactly one result, shown for one cycle with res_valid_o, which cannot be
// held off. A bilinear sample makes four texel reads through the single memory
// read port, then the two-step filter multiply. A write or add that allocates
// a tile first sweeps all 256 texel addresses of the tile's slot in texel
// memory to zero. A two-entry queue lets the front take new items while the
// back works; busy_o rises while the front handles an item or waits on a full
// queue.
module sparse_tiled_texel_store_bilinear (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  stt_pkg::item_t   item_i,
  output logic             busy_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [16:0]      cfg_data_i,
  output logic             res_valid_o,
  output stt_pkg::result_t result_o
);

  logic [2:0]  log2_q;
  logic [16:0] res_q;
  logic [2:0]  k;
  logic [16:0] r;

  logic           push, full, pop, qv;
  stt_pkg::qent_t push_data, pop_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_q <= 3'd3;
      res_q  <= 17'd1024;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == stt_pkg::REG_TILE_LOG2) begin
        log2_q <= cfg_data_i[2:0];
      end else begin
        res_q <= cfg_data_i;
      end
    end
  end

  // clamp to usable ranges
  always_comb begin
    if (log2_q < 3'd1) begin
      k = 3'd1;
    end else if (log2_q > 3'(stt_pkg::MAX_LOG2)) begin
      k = 3'(stt_pkg::MAX_LOG2);
    end else begin
      k = log2_q;
    end
    if (res_q == 17'd0) begin
      r = 17'd1;
    end else if (res_q > 17'd65536) begin
      r = 17'd65536;
    end else begin
      r = res_q;
    end
  end

  stt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy_o),
    .k_i         (k),
    .res_i       (r),
    .q_full_i    (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  stt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (qv),
    .pop_data_o  (pop_data)
  );

  stt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (qv),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .result_o    (result_o)
  );

endmodule

// File: tb/sv/sparse_tiled_texel_store_bilinear_tb.sv
// ----------------------------------------------------------------------------
// sparse_tiled_texel_store_bilinear_tb: self-checking bench of the texel store
// Drives write, add, read and sample items under several tile sides and
// resolutions, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_tiled_texel_store_bilinear_tb;

  localparam int SLOT_TEXELS = 256;
  localparam int MAX_SIDE    = 16;
  localparam int STALL_LIMIT = 3000;

  // texel store prediction and result checking
  class texel_scoreboard;
    bit        tile_vld [stt_pkg::TILE_SLOTS];
    longint    tile_cx  [stt_pkg::TILE_SLOTS];
    longint    tile_cy  [stt_pkg::TILE_SLOTS];
    int        texels   [stt_pkg::TILE_SLOTS*SLOT_TEXELS][3];
    int unsigned side_log2;
    int unsigned res_cfg;
    stt_pkg::result_t pending[$];
    int        mismatches;

    function void clear();
      foreach (tile_vld[i]) tile_vld[i] = 0;
      side_log2 = 3;
      res_cfg   = 1024;
      pending.delete();
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [16:0] data);
      if (idx == stt_pkg::REG_TILE_LOG2) side_log2 = data[2:0];
      else res_cfg = data;
    endfunction

    function int unsigned eff_log2();
      int unsigned k;
      k = (side_log2 < 1) ? 1 : side_log2;
      while (k > 1 && (1 << k) > MAX_SIDE) k--;
      return k;
    endfunction

    // texel index of (x,y), -1 when its tile is absent
    function int texel_index(longint x, longint y);
      int unsigned k;
      longint tx, ty;
      k  = eff_log2();
      tx = x >>> k;
      ty = y >>> k;
      for (int s = 0; s < stt_pkg::TILE_SLOTS; s++)
        if (tile_vld[s] && tile_cx[s] == tx && tile_cy[s] == ty)
          return s * SLOT_TEXELS + int'(((y & ((1 << k) - 1)) << k) | (x & ((1 << k) - 1)));
      return -1;
    endfunction

    // find or allocate; -1 when the table is full
    function int claim(longint x, longint y);
      int idx;
      int unsigned k;
      idx = texel_index(x, y);
      if (idx >= 0) return idx;
      k = eff_log2();
      for (int s = 0; s < stt_pkg::TILE_SLOTS; s++)
        if (!tile_vld[s]) begin
          tile_vld[s] = 1;
          tile_cx[s] = x >>> k;
          tile_cy[s] = y >>> k;
          for (int t = 0; t < SLOT_TEXELS; t++)
            for (int c = 0; c < 3; c++) texels[s*SLOT_TEXELS+t][c] = 0;
          return texel_index(x, y);
        end
      return -1;
    endfunction

    function longint tap(longint x, longint y, int c);
      int idx;
      idx = texel_index(x, y);
      return (idx < 0) ? 0 : longint'(texels[idx][c]);
    endfunction

    function void note(stt_pkg::item_t it);
      stt_pkg::result_t r;
      int idx;
      longint vals[3];
      longint sum, rr, bx, by, x0, y0, ax, ay;
      logic [63:0] b;
      r = '0;
      vals[0] = it.val_x;
      vals[1] = it.val_y;
      vals[2] = it.val_z;
      case (stt_pkg::cmd_e'(it.cmd))
        stt_pkg::CMD_WRITE, stt_pkg::CMD_ADD: begin
          idx = claim(it.coord_x, it.coord_y);
          if (idx < 0) r.status = 1'b1;
          else
            for (int c = 0; c < 3; c++) begin
              if (stt_pkg::cmd_e'(it.cmd) == stt_pkg::CMD_WRITE)
                texels[idx][c] = int'(vals[c]);
              else begin
                sum = longint'(texels[idx][c]) + vals[c];
                if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                texels[idx][c] = int'(sum);
              end
            end
        end
        stt_pkg::CMD_READ: begin
          r.res_x = 32'(tap(it.coord_x, it.coord_y, 0));
          r.res_y = 32'(tap(it.coord_x, it.coord_y, 1));
          r.res_z = 32'(tap(it.coord_x, it.coord_y, 2));
        end
        default: begin
          rr = (res_cfg < 1) ? 1 : ((res_cfg > 65536) ? 65536 : res_cfg);
          bx = longint'(it.u_pos) * rr + 32768;
          by = longint'(it.v_pos) * rr + 32768;
          x0 = (bx >> 16) - 1;
          y0 = (by >> 16) - 1;
          ax = bx & 16'hFFFF;
          ay = by & 16'hFFFF;
          for (int c = 0; c < 3; c++) begin
            sum = tap(x0, y0, c) * ((65536 - ax) * (65536 - ay))
                + tap(x0 + 1, y0, c) * (ax * (65536 - ay))
                + tap(x0, y0 + 1, c) * ((65536 - ax) * ay)
                + tap(x0 + 1, y0 + 1, c) * (ax * ay);
            b = (64'(sum) + 64'h8000_0000) ^ 64'h8000_0000_0000_0000;
            vals[c] = longint'(b >> 32) - 64'sh8000_0000;
          end
          r.res_x = vals[0][31:0];
          r.res_y = vals[1][31:0];
          r.res_z = vals[2][31:0];
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check(stt_pkg::result_t got);
      stt_pkg::result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.res_x !== want.res_x || got.res_y !== want.res_y ||
          got.res_z !== want.res_z || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                   want.res_x, want.res_y, want.res_z, want.status,
                   got.res_x, got.res_y, got.res_z, got.status);
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  stt_pkg::item_t   item_i = '0;
  logic             busy_o;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = stt_pkg::REG_TILE_LOG2;
  logic [16:0]      cfg_data_i = '0;
  logic             res_valid_o;
  stt_pkg::result_t result_o;

  texel_scoreboard sb = new();
  int  stall_cycles = 0;
  bit  no_gaps = 0;
  int  coord_span = 12;

  sparse_tiled_texel_store_bilinear dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // result check, sampled mid-cycle
  always @(negedge clk_i) begin
    if (res_valid_o) sb.check(result_o);
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o || cfg_we_i || !rst_ni) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send(stt_pkg::item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    forever begin
      @(negedge clk_i);
      if (!busy_o) begin
        sb.note(it);
        @(posedge clk_i);
        break;
      end
      @(posedge clk_i);
    end
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(logic idx, logic [16:0] data);
    start_i <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (20) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  function automatic stt_pkg::item_t make_item(stt_pkg::cmd_e op, shortint x, shortint y);
    stt_pkg::item_t it;
    it = '0;
    it.cmd = op;
    it.coord_x = x;
    it.coord_y = y;
    it.val_x = $urandom;
    it.val_y = $urandom;
    it.val_z = $urandom;
    return it;
  endfunction

  function automatic stt_pkg::item_t random_item();
    stt_pkg::item_t it;
    int unsigned rr, umax;
    it = make_item(stt_pkg::cmd_e'($urandom_range(0, 3)), '0, '0);
    // most coordinates in a small window so tiles get reused
    if ($urandom_range(0, 99) < 12) begin
      it.coord_x = 16'($urandom);
      it.coord_y = 16'($urandom);
    end else begin
      it.coord_x = 16'(int'($urandom_range(0, 2 * coord_span)) - coord_span);
      it.coord_y = 16'(int'($urandom_range(0, 2 * coord_span)) - coord_span);
    end
    case ($urandom_range(0, 5))
      0: it.val_x = 32'h7FFF_FFFF;
      1: it.val_y = 32'h8000_0000;
      2: it.val_z = $urandom_range(0, 1) ? 32'h7FFF_0000 : 32'h8000_FFFF;
      default: ;
    endcase
    rr = (sb.res_cfg < 1) ? 1 : ((sb.res_cfg > 65536) ? 65536 : sb.res_cfg);
    if ($urandom_range(0, 99) < 20) begin
      it.u_pos = 17'($urandom);
      it.v_pos = 17'($urandom);
    end else begin
      umax = ((coord_span + 2) << 16) / rr;
      if (umax > 131071) umax = 131071;
      it.u_pos = 17'($urandom_range(0, umax));
      it.v_pos = 17'($urandom_range(0, umax));
    end
    return it;
  endfunction

  initial begin
    stt_pkg::item_t it;
    int    tile_log2s [6] = '{1, 4, 0, 7, 2, 3};
    int    resolutions[6] = '{1, 65536, 0, 131071, 37, 1024};

    sb.clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, saturation, absent tiles, sample corners
    send(make_item(stt_pkg::CMD_READ, 16'sh7FFF, 16'sh7FFF));
    it = make_item(stt_pkg::CMD_WRITE, 16'sh7FFF, 16'sh7FFF);
    it.val_x = 32'h7FFF_FFFF; it.val_y = 32'h8000_0000; it.val_z = 32'hFFFF_FFFF;
    send(it);
    it.cmd = stt_pkg::CMD_ADD;
    it.val_x = 32'h0000_0001; it.val_y = 32'hFFFF_FFFF; it.val_z = 32'h0;
    send(it);
    send(make_item(stt_pkg::CMD_READ, 16'sh7FFF, 16'sh7FFF));
    it = make_item(stt_pkg::CMD_WRITE, -16'sd32768, -16'sd32768);
    send(it);
    send(make_item(stt_pkg::CMD_READ, -16'sd32768, -16'sd32768));
    for (int i = -1; i <= 1; i++)
      for (int j = -1; j <= 1; j++)
        send(make_item(stt_pkg::CMD_WRITE, shortint'(i), shortint'(j)));
    send(make_item(stt_pkg::CMD_ADD, 16'sd0, 16'sd0));
    send(make_item(stt_pkg::CMD_ADD, -16'sd1, 16'sd0));
    send(make_item(stt_pkg::CMD_READ, 16'sd0, 16'sd0));
    send(make_item(stt_pkg::CMD_READ, 16'sd5, -16'sd9));
    it = make_item(stt_pkg::CMD_SAMPLE, 16'sd0, 16'sd0);
    it.u_pos = 17'd0; it.v_pos = 17'd0;
    send(it);
    it.u_pos = 17'd65536; it.v_pos = 17'd65536;
    send(it);
    it.u_pos = 17'h1FFFF; it.v_pos = 17'h1FFFF;
    send(it);
    it.u_pos = 17'd32; it.v_pos = 17'd80;
    send(it);

    // random phases under several register settings
    for (int p = 0; p < 6; p++) begin
      write_reg(stt_pkg::REG_TILE_LOG2, 17'(tile_log2s[p]));
      write_reg(stt_pkg::REG_RES, 17'(resolutions[p]));
      coord_span = (p % 2 == 0) ? 12 : 40;
      for (int n = 0; n < 205; n++) begin
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        send(random_item());
      end
    end
    start_i <= 1'b0;

    wait (sb.pending.size() == 0);
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
